[sv/slpq_pkg.sv]
// ----------------------------------------------------------------------------
// slpq_pkg: shared types and constants for the sorted-list priority queue
// Node store geometry, operation and status codes, word types, the
// controller/datapath command and status bundles and the priority relation.
// ----------------------------------------------------------------------------
package slpq_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LINK_W   = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_PEEK = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] MODE_LE = 2'd0;
  localparam logic [1:0] MODE_LT = 2'd1;
  localparam logic [1:0] MODE_GE = 2'd2;
  localparam logic [1:0] MODE_GT = 2'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } pq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_value;
    logic signed [DATA_W-1:0] out_priority;
    logic                     now_empty;
  } pq_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH1,
    ST_WALK_LINK,
    ST_WALK_CHK,
    ST_FIN1,
    ST_FIN2,
    ST_POP1,
    ST_DONE
  } state_t;

  // read address source
  typedef enum logic [1:0] {
    RA_HEAD,
    RA_FREE,
    RA_LINK
  } ra_sel_t;

  // link write address source
  typedef enum logic [1:0] {
    WA_SLOT,
    WA_CUR,
    WA_HEAD
  } wa_sel_t;

  // link write data source
  typedef enum logic [1:0] {
    WD_HEAD,
    WD_NXT,
    WD_SLOT,
    WD_FREE
  } wd_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       dat_we;
    logic       dat_re;
    ra_sel_t    dat_ra;
    logic       lnk_re;
    ra_sel_t    lnk_ra;
    logic       lnk_we;
    wa_sel_t    lnk_wa;
    wd_sel_t    lnk_wd;
    logic       slot_ld;
    logic       free_from_link;
    logic       free_from_head;
    logic       head_from_slot;
    logic       head_from_link;
    logic       cur_from_head;
    logic       cur_from_nxt;
    logic       nxt_from_link;
    logic       nxt_null;
    logic       emit;
    logic       emit_data;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       head_null;
    logic       free_null;
    logic       link_null;
    logic       past;
  } dp_sts_t;

  function automatic logic is_slot(input logic [LINK_W-1:0] x);
    return x < LINK_W'(CAPACITY);
  endfunction

  // true while the walk should step past the stored node
  function automatic logic walk_past(input logic [1:0] mode,
                                     input logic signed [DATA_W-1:0] stored,
                                     input logic signed [DATA_W-1:0] incoming);
    logic r;
    unique case (mode)
      MODE_LE: r = stored <= incoming;
      MODE_LT: r = stored <  incoming;
      MODE_GE: r = stored >= incoming;
      MODE_GT: r = stored >  incoming;
    endcase
    return r;
  endfunction

endpackage

[sv/slpq_dp.sv]
// ----------------------------------------------------------------------------
// slpq_dp: node store and pointer datapath
// Value, priority and link memories, head/free/walk pointers, order mode
// register and the result word register.
// ----------------------------------------------------------------------------
module slpq_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  slpq_pkg::pq_in_t  in_data,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_data,
  input  slpq_pkg::dp_cmd_t cmd,
  output slpq_pkg::dp_sts_t sts,
  output logic             out_valid,
  output slpq_pkg::pq_out_t out_data
);
  import slpq_pkg::*;

  logic [DATA_W-1:0] val_mem [CAPACITY];
  logic [DATA_W-1:0] pri_mem [CAPACITY];
  logic [LINK_W-1:0] lnk_mem [CAPACITY];
  logic [CAPACITY-1:0] lnk_vld_r;

  logic [DATA_W-1:0] val_rd_r, pri_rd_r;
  logic [LINK_W-1:0] lnk_rd_r;
  logic              lnk_vld_rd_r;
  logic [SLOT_W-1:0] lnk_ra_rd_r;

  logic [LINK_W-1:0] head_r, free_r, slot_r, cur_r, nxt_r;
  logic [1:0]        mode_r;
  logic [1:0]        func_r;
  logic [DATA_W-1:0] item_val_r, item_pri_r;
  logic              out_valid_r;
  pq_out_t           out_data_r;

  logic [LINK_W-1:0] link_raw, link_q, lnk_wdata;
  logic [SLOT_W-1:0] dat_ra, lnk_ra, lnk_wa;

  // never-written link entries read as their reset chain value
  assign link_raw = lnk_vld_rd_r ? lnk_rd_r : LINK_W'(lnk_ra_rd_r) + LINK_W'(1);
  assign link_q   = is_slot(link_raw) ? link_raw : NULL_LINK;

  always_comb begin
    unique case (cmd.dat_ra)
      RA_HEAD: dat_ra = head_r[SLOT_W-1:0];
      RA_FREE: dat_ra = free_r[SLOT_W-1:0];
      RA_LINK: dat_ra = link_q[SLOT_W-1:0];
      default: dat_ra = head_r[SLOT_W-1:0];
    endcase
    unique case (cmd.lnk_ra)
      RA_HEAD: lnk_ra = head_r[SLOT_W-1:0];
      RA_FREE: lnk_ra = free_r[SLOT_W-1:0];
      RA_LINK: lnk_ra = link_q[SLOT_W-1:0];
      default: lnk_ra = head_r[SLOT_W-1:0];
    endcase
    unique case (cmd.lnk_wa)
      WA_SLOT: lnk_wa = slot_r[SLOT_W-1:0];
      WA_CUR:  lnk_wa = cur_r[SLOT_W-1:0];
      WA_HEAD: lnk_wa = head_r[SLOT_W-1:0];
      default: lnk_wa = slot_r[SLOT_W-1:0];
    endcase
    unique case (cmd.lnk_wd)
      WD_HEAD: lnk_wdata = head_r;
      WD_NXT:  lnk_wdata = nxt_r;
      WD_SLOT: lnk_wdata = slot_r;
      WD_FREE: lnk_wdata = free_r;
    endcase
  end

  // value and priority memories
  always_ff @(posedge clk) begin
    if (cmd.dat_we) begin
      val_mem[free_r[SLOT_W-1:0]] <= item_val_r;
      pri_mem[free_r[SLOT_W-1:0]] <= item_pri_r;
    end
    if (cmd.dat_re) begin
      val_rd_r <= val_mem[dat_ra];
      pri_rd_r <= pri_mem[dat_ra];
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (cmd.lnk_we) begin
      lnk_mem[lnk_wa] <= lnk_wdata;
    end
    if (cmd.lnk_re) begin
      lnk_rd_r     <= lnk_mem[lnk_ra];
      lnk_vld_rd_r <= lnk_vld_r[lnk_ra];
      lnk_ra_rd_r  <= lnk_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnk_vld_r   <= '0;
      head_r      <= NULL_LINK;
      free_r      <= '0;
      mode_r      <= MODE_LE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.lnk_we) begin
        lnk_vld_r[lnk_wa] <= 1'b1;
      end
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      if (cmd.head_from_slot) begin
        head_r <= slot_r;
      end else if (cmd.head_from_link) begin
        head_r <= link_q;
      end
      if (cmd.free_from_link) begin
        free_r <= link_q;
      end else if (cmd.free_from_head) begin
        free_r <= head_r;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r     <= in_data.func;
      item_val_r <= in_data.item_value;
      item_pri_r <= in_data.item_priority;
    end
    if (cmd.slot_ld) begin
      slot_r <= free_r;
    end
    if (cmd.cur_from_head) begin
      cur_r <= head_r;
    end else if (cmd.cur_from_nxt) begin
      cur_r <= nxt_r;
    end
    if (cmd.nxt_null) begin
      nxt_r <= NULL_LINK;
    end else if (cmd.nxt_from_link) begin
      nxt_r <= link_q;
    end
    if (cmd.emit) begin
      out_data_r.status       <= cmd.status;
      out_data_r.out_value    <= cmd.emit_data ? val_rd_r : '0;
      out_data_r.out_priority <= cmd.emit_data ? pri_rd_r : '0;
      out_data_r.now_empty    <= !is_slot(head_r);
    end
  end

  assign sts.func      = func_r;
  assign sts.head_null = !is_slot(head_r);
  assign sts.free_null = !is_slot(free_r);
  assign sts.link_null = !is_slot(link_q);
  assign sts.past      = walk_past(mode_r, pri_rd_r, item_pri_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/slpq_ctrl.sv]
// ----------------------------------------------------------------------------
// slpq_ctrl: operation sequencer
// Steps push, pop and peek through the node store.
// ----------------------------------------------------------------------------
module slpq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  slpq_pkg::dp_sts_t sts,
  output slpq_pkg::dp_cmd_t cmd
);
  import slpq_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  logic       dok_r, dok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      st_r    <= STATUS_OK;
      dok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      dok_r   <= dok_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    dok_nxt   = dok_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        st_nxt  = STATUS_OK;
        dok_nxt = 1'b0;
        unique case (sts.func)
          FUNC_PUSH: begin
            if (sts.free_null) begin
              st_nxt    = STATUS_FULL;
              state_nxt = ST_DONE;
            end else begin
              // store the item, fetch head priority and next free slot
              cmd.dat_we  = 1'b1;
              cmd.dat_re  = 1'b1;
              cmd.dat_ra  = RA_HEAD;
              cmd.lnk_re  = 1'b1;
              cmd.lnk_ra  = RA_FREE;
              cmd.slot_ld = 1'b1;
              state_nxt   = ST_PUSH1;
            end
          end
          FUNC_POP, FUNC_PEEK: begin
            if (sts.head_null) begin
              st_nxt    = STATUS_EMPTY;
              state_nxt = ST_DONE;
            end else begin
              cmd.dat_re = 1'b1;
              cmd.dat_ra = RA_HEAD;
              cmd.lnk_re = 1'b1;
              cmd.lnk_ra = RA_HEAD;
              state_nxt  = ST_POP1;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_PUSH1: begin
        cmd.free_from_link = 1'b1;
        if (sts.head_null || !sts.past) begin
          cmd.lnk_we         = 1'b1;
          cmd.lnk_wa         = WA_SLOT;
          cmd.lnk_wd         = WD_HEAD;
          cmd.head_from_slot = 1'b1;
          state_nxt          = ST_DONE;
        end else begin
          cmd.cur_from_head = 1'b1;
          cmd.lnk_re        = 1'b1;
          cmd.lnk_ra        = RA_HEAD;
          state_nxt         = ST_WALK_LINK;
        end
      end
      ST_WALK_LINK: begin
        if (sts.link_null) begin
          cmd.nxt_null = 1'b1;
          state_nxt    = ST_FIN1;
        end else begin
          cmd.nxt_from_link = 1'b1;
          cmd.dat_re        = 1'b1;
          cmd.dat_ra        = RA_LINK;
          cmd.lnk_re        = 1'b1;
          cmd.lnk_ra        = RA_LINK;
          state_nxt         = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (sts.past) begin
          cmd.cur_from_nxt = 1'b1;
          if (sts.link_null) begin
            cmd.nxt_null = 1'b1;
            state_nxt    = ST_FIN1;
          end else begin
            cmd.nxt_from_link = 1'b1;
            cmd.dat_re        = 1'b1;
            cmd.dat_ra        = RA_LINK;
            cmd.lnk_re        = 1'b1;
            cmd.lnk_ra        = RA_LINK;
          end
        end else begin
          state_nxt = ST_FIN1;
        end
      end
      ST_FIN1: begin
        cmd.lnk_we = 1'b1;
        cmd.lnk_wa = WA_SLOT;
        cmd.lnk_wd = WD_NXT;
        state_nxt  = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.lnk_we = 1'b1;
        cmd.lnk_wa = WA_CUR;
        cmd.lnk_wd = WD_SLOT;
        state_nxt  = ST_DONE;
      end
      ST_POP1: begin
        dok_nxt = 1'b1;
        if (sts.func == FUNC_POP) begin
          cmd.head_from_link = 1'b1;
          cmd.free_from_head = 1'b1;
          cmd.lnk_we         = 1'b1;
          cmd.lnk_wa         = WA_HEAD;
          cmd.lnk_wd         = WD_FREE;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit      = 1'b1;
        cmd.emit_data = dok_r;
        cmd.status    = st_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/sorted_list_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_unit: priority queue on a sorted linked list
// Pop/peek and push each answer with one result strobe after start is taken.
// Push lands at the head or walks the list past the nodes after the head,
// with one link-memory read per walk step.
// Empty/full errors and unused codes also strobe a result. Sync reset, empty queue.
// ----------------------------------------------------------------------------
module sorted_list_priority_queue_unit (
  input  logic              clk,
  input  logic              rst_n,
  // command word
  input  logic              start,
  output logic              busy,
  input  slpq_pkg::pq_in_t  in_data,
  // result word, one strobe cycle, cannot be held off
  output logic              out_valid,
  output slpq_pkg::pq_out_t out_data,
  // order mode register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);
  import slpq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The mode register takes a write at any time; the user only writes it
  // while busy is low and no result is pending.
  assign cfg_ready = 1'b1;

  // Sequencer: steps each operation through its states, walk advances one node a cycle.
  slpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Node store, free list, head pointer and result register.
  slpq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/sorted_list_priority_queue_unit_tb.sv]
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_unit_tb: self-checking bench for the sorted-list
// priority queue.
// Commands go in one word at a time on the start/busy handshake. An internal
// copy of the node store, the sorted list and the free list predicts each
// result word. A monitor compares every strobed result field by field with
// the oldest prediction. Directed cases (empty queue, priority extremes, ties,
// unused code, full store) come first. Random traffic follows under all four
// order modes, with bursts of sender idling in the first three.
// ----------------------------------------------------------------------------
module sorted_list_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slpq_pkg::*;

  // func 3 is not assigned; the block must answer ok with zero data
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int STALL_LIMIT  = 1000; // idle cycles before the run is abandoned
  localparam int DRAIN_CYCLES = 12;   // settle time after the last result word
  localparam int MAX_REPORTS  = 10;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  pq_in_t  in_data = '0;
  logic    out_valid;
  pq_out_t out_data;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [1:0] cfg_data = MODE_LE;

  sorted_list_priority_queue_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow copy of the queue: node store, links, list heads and order mode
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] node_val [CAPACITY];
  logic signed [DATA_W-1:0] node_pri [CAPACITY];
  logic [LINK_W-1:0]        node_next [CAPACITY];
  logic [LINK_W-1:0]        head_ptr;
  logic [LINK_W-1:0]        free_ptr;
  logic [1:0]               order_sel;

  // Result words predicted but not yet seen, oldest first
  pq_out_t answers_due [$];

  int errors;
  int mismatches;
  int words_sent;
  int words_checked;
  int full_drops;
  int empty_hits;
  int max_depth;
  int depth;
  int idle_pct;
  int stall_cycles = 0;

  // Restore the post-reset queue: every slot free and chained in order
  task automatic clear_shadow();
    for (int i = 0; i < CAPACITY; i++) begin
      node_val[i]  = '0;
      node_pri[i]  = '0;
      node_next[i] = (i == CAPACITY - 1) ? NULL_LINK : LINK_W'(i + 1);
    end
    head_ptr  = NULL_LINK;
    free_ptr  = '0;
    order_sel = MODE_LE;
    depth     = 0;
  endtask

  function automatic logic live(input logic [LINK_W-1:0] ptr);
    return ptr < LINK_W'(CAPACITY);
  endfunction

  // True while the insertion walk keeps going past a stored node
  function automatic logic goes_past(input logic signed [DATA_W-1:0] stored,
                                     input logic signed [DATA_W-1:0] incoming);
    case (order_sel)
      MODE_LE: return stored <= incoming;
      MODE_LT: return stored <  incoming;
      MODE_GE: return stored >= incoming;
      default: return stored >  incoming;
    endcase
  endfunction

  // Apply one command word to the shadow queue and return its result word
  function automatic pq_out_t apply_command(input pq_in_t cmd);
    pq_out_t           ans;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] cur;
    int                steps;
    ans = '0;
    ans.status = STATUS_OK;
    case (cmd.func)
      FUNC_PUSH: begin
        if (!live(free_ptr)) begin
          ans.status = STATUS_FULL;
          full_drops++;
        end else begin
          slot = free_ptr[SLOT_W-1:0];
          free_ptr = node_next[slot];
          node_val[slot] = cmd.item_value;
          node_pri[slot] = cmd.item_priority;
          if (!live(head_ptr) ||
              !goes_past(node_pri[head_ptr[SLOT_W-1:0]], cmd.item_priority)) begin
            // new head
            node_next[slot] = live(head_ptr) ? head_ptr : NULL_LINK;
            head_ptr = LINK_W'(slot);
          end else begin
            // advance while the next node still sorts ahead of the new one
            cur = head_ptr[SLOT_W-1:0];
            steps = 0;
            while (steps < CAPACITY && live(node_next[cur]) &&
                   goes_past(node_pri[node_next[cur][SLOT_W-1:0]],
                             cmd.item_priority)) begin
              cur = node_next[cur][SLOT_W-1:0];
              steps++;
            end
            node_next[slot] = live(node_next[cur]) ? node_next[cur] : NULL_LINK;
            node_next[cur] = LINK_W'(slot);
          end
          depth++;
          if (depth > max_depth) max_depth = depth;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (!live(head_ptr)) begin
          ans.status = STATUS_EMPTY;
          empty_hits++;
        end else begin
          slot = head_ptr[SLOT_W-1:0];
          ans.out_value = node_val[slot];
          ans.out_priority = node_pri[slot];
          if (cmd.func == FUNC_POP) begin
            // unlink the head and return its slot to the front of the free list
            head_ptr = live(node_next[slot]) ? node_next[slot] : NULL_LINK;
            node_next[slot] = live(free_ptr) ? free_ptr : NULL_LINK;
            free_ptr = LINK_W'(slot);
            depth--;
          end
        end
      end
      default: ;
    endcase
    ans.now_empty = !live(head_ptr);
    return ans;
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor: one strobed word per command, compared field by field
  // --------------------------------------------------------------------------
  function automatic void report_mismatch(input string what, input pq_out_t want,
                                          input pq_out_t got);
    errors++;
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%t mismatch (%s): exp st=%0d val=%h pri=%h emp=%b,",
               $realtime, what, want.status, want.out_value, want.out_priority,
               want.now_empty, " got st=%0d val=%h pri=%h emp=%b",
               got.status, got.out_value, got.out_priority, got.now_empty);
  endfunction

  always @(posedge clk) begin
    pq_out_t want;
    string   bad;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        report_mismatch("no command pending", '0, out_data);
      end else begin
        want = answers_due.pop_front();
        words_checked++;
        bad = "";
        if (out_data.status !== want.status) bad = {bad, " status"};
        if (out_data.out_value !== want.out_value) bad = {bad, " value"};
        if (out_data.out_priority !== want.out_priority) bad = {bad, " priority"};
        if (out_data.now_empty !== want.now_empty) bad = {bad, " now_empty"};
        if (bad != "") report_mismatch({"field", bad}, want, out_data);
      end
    end
  end

  // Watchdog: abandon the run when no handshake of any kind completes for long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               stall_cycles, answers_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Hold start and the word until the block takes it, then predict its result.
  // Start stays high so back-to-back words need no new edge on it.
  task automatic send_word(input pq_in_t cmd);
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    answers_due.push_back(apply_command(cmd));
    words_sent++;
  endtask

  // Optionally drop start for a random burst, then send one word
  task automatic issue(input logic [1:0] func, input logic [DATA_W-1:0] value,
                       input logic [DATA_W-1:0] prio);
    pq_in_t cmd;
    cmd.func = func;
    cmd.item_value = value;
    cmd.item_priority = prio;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    send_word(cmd);
  endtask

  // Drop start and wait until every result word is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write the order mode; only called with the block drained
  task automatic write_order(input logic [1:0] mode);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_sel = mode;
  endtask

  // Priorities: full range, a narrow band that makes ties common, and extremes
  function automatic logic [DATA_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return DATA_W'($signed($urandom_range(0, 8)) - 4);
      8:          return 32'h8000_0000;
      default:    return 32'h7fff_ffff;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Pop, peek and the unused code on the queue straight out of reset
  task automatic test_empty_queue();
    issue(FUNC_PEEK, 32'hffff_ffff, 32'hffff_ffff);
    issue(FUNC_POP, 32'h0, 32'h0);
    issue(FUNC_UNUSED, 32'h1234_5678, 32'h8765_4321);
  endtask

  // Priority and value extremes, ties on both sides of the relation
  task automatic test_directed_order();
    // ascending mode: equal priorities land after the ones already stored
    issue(FUNC_PUSH, 32'h7fff_ffff, 32'h0000_0000);
    issue(FUNC_PUSH, 32'h8000_0000, 32'h8000_0000);
    issue(FUNC_PUSH, 32'hffff_ffff, 32'h7fff_ffff);
    issue(FUNC_PUSH, 32'h0000_0000, 32'hffff_ffff);
    issue(FUNC_PUSH, 32'h0000_0001, 32'h0000_0000);
    issue(FUNC_PUSH, 32'h0000_0002, 32'h0000_0000);
    issue(FUNC_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    issue(FUNC_PEEK, 32'h0, 32'h0);
    repeat (6) issue(FUNC_POP, 32'h0, 32'h0);
    issue(FUNC_POP, 32'h0, 32'h0);
    // strict descending mode: equal priorities land ahead of stored ones
    write_order(MODE_GT);
    issue(FUNC_PUSH, 32'h0000_00a1, 32'h0000_0005);
    issue(FUNC_PUSH, 32'h0000_00b2, 32'h0000_0005);
    issue(FUNC_PUSH, 32'h0000_00c3, 32'h0000_0006);
    issue(FUNC_PUSH, 32'h0000_00d4, 32'h0000_0005);
    issue(FUNC_PEEK, 32'h0, 32'h0);
    repeat (4) issue(FUNC_POP, 32'h0, 32'h0);
  endtask

  // Fill every slot, push past full, then empty the store again
  task automatic test_full_store();
    write_order(MODE_LT);
    repeat (CAPACITY) issue(FUNC_PUSH, $urandom, pick_priority());
    issue(FUNC_PUSH, $urandom, pick_priority());
    issue(FUNC_PUSH, $urandom, pick_priority());
    issue(FUNC_UNUSED, $urandom, $urandom);
    issue(FUNC_PEEK, $urandom, $urandom);
    repeat (CAPACITY + 1) issue(FUNC_POP, $urandom, $urandom);
  endtask

  // Random traffic in episodes; each episode draws its own push bias so the
  // queue swings between empty, half full and full
  task automatic test_random_traffic(input logic [1:0] mode, input int count,
                                     input int gap_pct);
    int sent;
    int bias;
    int pick;
    write_order(mode);
    idle_pct = gap_pct;
    sent = 0;
    while (sent < count) begin
      bias = $urandom_range(20, 85);
      // some episodes run with the sender flat out
      if (gap_pct > 0) idle_pct = ($urandom_range(0, 3) == 0) ? 0 : gap_pct;
      repeat (40) begin
        pick = $urandom_range(0, 99);
        if (pick < bias) begin
          issue(FUNC_PUSH, $urandom, pick_priority());
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: issue(FUNC_POP, $urandom, $urandom);
            7, 8:                issue(FUNC_PEEK, $urandom, $urandom);
            default:             issue(FUNC_UNUSED, $urandom, $urandom);
          endcase
        end
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    errors = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    full_drops = 0;
    empty_hits = 0;
    max_depth = 0;
    idle_pct = 0;
    clear_shadow();

    // hold reset, then release it once
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 25;
    test_empty_queue();
    test_directed_order();
    test_full_store();
    test_random_traffic(MODE_LE, 400, 30);
    test_random_traffic(MODE_GE, 400, 20);
    test_random_traffic(MODE_GT, 400, 40);
    // last stretch: no idling on the sender side
    test_random_traffic(MODE_LT, 360, 0);
    drain();

    // anything still predicted never came back
    if (answers_due.size() != 0) begin
      $display("%0d result words never arrived", answers_due.size());
      errors += answers_due.size();
    end

    $display("Sent %0d command words in all four order modes, checked %0d results.",
             words_sent, words_checked);
    $display("Pushes dropped on a full store: %0d, pops/peeks on empty: %0d, deepest: %0d.",
             full_drops, empty_hits, max_depth);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
